>>> rtl/us_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 sanitizer package
// Shared types, constants and the sequence decoder used to parse the held
// bytes and the incoming byte into result bytes and a new held prefix.
// ----------------------------------------------------------------------------
package us_pkg;

  localparam int MaxResults = 12;
  localparam int CntW       = $clog2(MaxResults + 1);
  localparam int BufLen     = 4;
  localparam int HeldLen    = 3;

  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;

  localparam logic [7:0] LeadE0 = 8'hE0;
  localparam logic [7:0] LeadED = 8'hED;
  localparam logic [7:0] LeadF0 = 8'hF0;
  localparam logic [7:0] LeadF4 = 8'hF4;

  typedef logic [BufLen-1:0][7:0]     byte_vec_t;
  typedef logic [HeldLen-1:0][7:0]    held_vec_t;
  typedef logic [MaxResults-1:0][7:0] res_vec_t;

  typedef struct packed {
    res_vec_t        bytes;
    logic [CntW-1:0] count;
    logic            str_last;
  } result_t;

  typedef struct packed {
    result_t    res;
    held_vec_t  held;
    logic [1:0] held_count;
  } parse_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b < 8'h80) begin
      len = 3'd1;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      len = 3'd2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      len = 3'd3;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic prefix_ok(input byte_vec_t b, input logic [1:0] p,
                                     input logic [2:0] m, input logic [2:0] len);
    logic       ok;
    logic [7:0] c0;
    logic [7:0] c1;
    ok = 1'b1;
    c0 = b[p];
    c1 = b[p + 2'd1];
    for (int k = 1; k < BufLen; k++) begin
      if (3'(k) < m && b[p + 2'(k)][7:6] != 2'b10) begin
        ok = 1'b0;
      end
    end
    if (m >= 3'd2) begin
      if (len == 3'd3 && c0 == LeadE0 && c1 < 8'hA0) ok = 1'b0;
      if (len == 3'd3 && c0 == LeadED && c1 > 8'h9F) ok = 1'b0;
      if (len == 3'd4 && c0 == LeadF0 && c1 < 8'h90) ok = 1'b0;
      if (len == 3'd4 && c0 == LeadF4 && c1 > 8'h8F) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic result_t push_byte(input result_t r, input logic [7:0] b);
    result_t q;
    q = r;
    if (q.count < CntW'(MaxResults)) begin
      q.bytes[q.count] = b;
      q.count = q.count + CntW'(1);
    end
    return q;
  endfunction

  function automatic result_t push_repl(input result_t r);
    result_t q;
    q = push_byte(r, ReplByte0);
    q = push_byte(q, ReplByte1);
    q = push_byte(q, ReplByte2);
    return q;
  endfunction

  // Walk the buffer lead by lead; each pass consumes at least one byte.
  function automatic parse_t parse_seq(input byte_vec_t b, input logic [2:0] n,
                                       input logic last);
    parse_t     r;
    logic [2:0] pos;
    logic [2:0] avail;
    logic [2:0] len;
    logic [2:0] m;
    logic       ok;
    logic       stop;
    r    = '0;
    pos  = 3'd0;
    stop = 1'b0;
    for (int s = 0; s < BufLen; s++) begin
      if (!stop && pos < n) begin
        avail = n - pos;
        len   = lead_length(b[pos[1:0]]);
        m     = (avail < len) ? avail : len;
        ok    = (len != 3'd0) && prefix_ok(b, pos[1:0], m, len);
        if (!ok || (avail < len && last)) begin
          r.res = push_repl(r.res);
          pos   = pos + 3'd1;
        end else if (avail >= len) begin
          for (int k = 0; k < BufLen; k++) begin
            if (3'(k) < len) begin
              r.res = push_byte(r.res, b[pos[1:0] + 2'(k)]);
            end
          end
          pos = pos + len;
        end else begin
          for (int k = 0; k < HeldLen; k++) begin
            if (3'(k) < avail) begin
              r.held[k] = b[pos[1:0] + 2'(k)];
            end
          end
          r.held_count = avail[1:0];
          stop         = 1'b1;
        end
      end
    end
    r.res.str_last = last;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/us_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Raw byte channel
// Valid/ready channel carrying one raw byte and its end-of-string mark.
// ----------------------------------------------------------------------------
interface us_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface
`default_nettype wire

>>> rtl/us_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sanitized byte channel
// Valid/ready channel carrying one output byte with its run and string marks.
// ----------------------------------------------------------------------------
interface us_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output out_byte, output run_last,
                  output string_done, input ready);
  modport sink (input valid, input out_byte, input run_last,
                input string_done, output ready);
endinterface
`default_nettype wire

>>> rtl/us_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result emitter
// Holds one input transaction's result bytes and streams them one per cycle
// while tx is ready; frees itself for a new load as its final byte leaves.
// ----------------------------------------------------------------------------
module us_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire us_pkg::result_t res,
  output logic                 free,
  us_out_if.source             tx
);
  import us_pkg::*;

  res_vec_t        bytes;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] rd;
  logic            str_last;
  logic            at_end;
  logic            fire;

  assign at_end = (rd == cnt - CntW'(1));
  assign fire   = tx.valid && tx.ready;
  assign free   = (cnt == '0) || (fire && at_end);

  assign tx.valid       = (cnt != '0);
  assign tx.out_byte    = bytes[rd];
  assign tx.run_last    = at_end;
  assign tx.string_done = at_end && str_last;

  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= res.bytes;
      str_last <= res.str_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else if (load) begin
      cnt <= res.count;
      rd  <= '0;
    end else if (fire) begin
      if (at_end) begin
        cnt <= '0;
        rd  <= '0;
      end else begin
        rd <= rd + CntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(MaxResults))
    else $error("result count beyond capacity");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    tx.valid |-> rd < cnt)
    else $error("read index past result count");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("load while results still pending");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (fire && at_end && !load) |=> !tx.valid)
    else $error("emitter still valid after final byte");

endmodule
`default_nettype wire

>>> rtl/utf8_sanitizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 sanitizer
// Takes raw bytes with an end-of-string mark and emits the sanitized string,
// passing well-formed UTF-8 and replacing each bad lead with EF BF BD.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one raw byte per transaction, end_of_string on the final byte.
//   tx carries the sanitized bytes; run_last marks the last byte caused by an
//   input transaction, string_done the final byte of the string.
//   An input byte is decoded together with up to three held bytes in the
//   cycle it is taken; its results appear on tx from the next cycle, one
//   byte per cycle. An input transaction yields 0 to 12 output bytes.
//   rx is ready whenever the result register is empty or its final byte
//   leaves in this cycle, so plain text flows at one byte per cycle; a
//   multi-byte result holds rx off until its last byte leaves. Bytes of an
//   incomplete sequence are held and yield nothing until it resolves.
//   When tx stalls, the current output byte holds and rx waits.
//   Reset empties the held prefix and the result register; the block is
//   ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module utf8_sanitizer (
  input  wire logic clk,
  input  wire logic rst,
  us_in_if.sink     rx,
  us_out_if.source  tx
);
  import us_pkg::*;

  held_vec_t  held;
  logic [1:0] held_count;
  byte_vec_t  buf_bytes;
  parse_t     parsed;
  logic       accept;
  logic       free;

  always_comb begin
    for (int k = 0; k < BufLen; k++) begin
      if (k < HeldLen && 2'(k) < held_count) begin
        buf_bytes[k] = held[k[1:0]];
      end else if (3'(k) == {1'b0, held_count}) begin
        buf_bytes[k] = rx.in_byte;
      end else begin
        buf_bytes[k] = 8'h00;
      end
    end
  end

  assign parsed   = parse_seq(buf_bytes, {1'b0, held_count} + 3'd1, rx.end_of_string);
  assign rx.ready = free;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= parsed.held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      held_count <= parsed.held_count;
    end
  end

  us_emit u_emit (
    .clk  (clk),
    .rst  (rst),
    .load (accept),
    .res  (parsed.res),
    .free (free),
    .tx   (tx)
  );

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && rx.end_of_string) |=> held_count == 2'd0)
    else $error("held bytes survive end of string");

  a_end_yields: assert property (@(posedge clk) disable iff (rst)
    (accept && rx.end_of_string) |=> tx.valid)
    else $error("end of string produced no output");

  a_step_progress: assert property (@(posedge clk) disable iff (rst)
    accept |-> ((parsed.res.count != '0) || (parsed.held_count != 2'd0)))
    else $error("input transaction neither emitted nor held");

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizer testbench
// Feeds directed and random byte strings (mostly well-formed UTF-8 with
// truncated, corrupted and noise characters mixed in) through the sanitizer.
// Each accepted byte is run through a local decoder that predicts the cleaned
// output bytes and their run and string marks. The output stream is checked
// against those predictions while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import us_pkg::*;

  localparam int CycleLimit = 200_000;
  localparam int HoldCycles = 300;
  localparam int TailCycles = 20;
  localparam int PrintCap   = 200;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    int         idle_pct;
    int         stall_pct;
    bit         drain;
    bit         hold;
  } raw_item_t;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
  } clean_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  us_in_if  rx_if ();
  us_out_if tx_if ();

  utf8_sanitizer uut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .tx (tx_if)
  );

  raw_item_t   raw_q [$];
  raw_item_t   cur_item;
  clean_byte_t clean_q [$];
  clean_byte_t run_q [$];

  logic [7:0]  held_b [3];
  logic [1:0]  held_n = 2'd0;
  logic [2:0]  want_len = 3'd0;

  int          err_count = 0;
  int unsigned cycle_count = 0;
  int          stall_pct_now = 0;
  int          hold_left = 0;
  logic        hold_kick = 1'b0;

  logic [8:0]  warmup [26] = '{
    9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h1BF,
    9'h0E0, 9'h0A0, 9'h080, 9'h0E0, 9'h09F, 9'h0ED, 9'h0A0,
    9'h0F0, 9'h08F, 9'h0F4, 9'h090, 9'h0F5, 9'h0FF, 9'h0C1,
    9'h0F0, 9'h090, 9'h080, 9'h0C0, 9'h0E2, 9'h182
  };

  int phase_idle [4]  = '{0, 53, 0, 33};
  int phase_stall [4] = '{0, 0, 53, 33};

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= PrintCap) begin
      $display("mismatch %s: got %02h expected %02h at cycle %0d", what, got, want,
               cycle_count);
    end
  endtask

  task automatic add_clean(input logic [7:0] b);
    clean_byte_t cb;
    cb.data    = b;
    cb.run_end = 1'b0;
    cb.str_end = 1'b0;
    if (run_q.size() < MaxResults) run_q.insert(run_q.size(), cb);
  endtask

  task automatic sanitize_step(input logic [7:0] b, input logic eos);
    logic [7:0] seq [4];
    int         n;
    int         pos;
    int         avail;
    int         len;
    int         m;
    logic       ok;
    run_q.delete();
    for (int k = 0; k < int'(held_n); k++) seq[k] = held_b[k];
    seq[held_n] = b;
    n = int'(held_n) + 1;
    held_n = 2'd0;
    want_len = 3'd0;
    pos = 0;
    while (pos < n) begin
      avail = n - pos;
      if (seq[pos] < 8'h80) len = 1;
      else if (seq[pos] >= 8'hC2 && seq[pos] <= 8'hDF) len = 2;
      else if (seq[pos] >= 8'hE0 && seq[pos] <= 8'hEF) len = 3;
      else if (seq[pos] >= 8'hF0 && seq[pos] <= 8'hF4) len = 4;
      else len = 0;
      m = (avail < len) ? avail : len;
      ok = (len != 0);
      for (int k = 1; k < m; k++) begin
        if (seq[pos + k][7:6] != 2'b10) ok = 1'b0;
      end
      if (m >= 2) begin
        if (len == 3 && seq[pos] == 8'hE0 && seq[pos + 1] < 8'hA0) ok = 1'b0;
        if (len == 3 && seq[pos] == 8'hED && seq[pos + 1] > 8'h9F) ok = 1'b0;
        if (len == 4 && seq[pos] == 8'hF0 && seq[pos + 1] < 8'h90) ok = 1'b0;
        if (len == 4 && seq[pos] == 8'hF4 && seq[pos + 1] > 8'h8F) ok = 1'b0;
      end
      if (!ok || (avail < len && eos)) begin
        add_clean(ReplByte0);
        add_clean(ReplByte1);
        add_clean(ReplByte2);
        pos++;
      end else if (avail >= len) begin
        for (int k = 0; k < len; k++) add_clean(seq[pos + k]);
        pos += len;
      end else begin
        for (int k = 0; k < avail; k++) held_b[k] = seq[pos + k];
        held_n = 2'(avail);
        want_len = 3'(len);
        pos = n;
      end
    end
    if (run_q.size() != 0) begin
      run_q[$].run_end = 1'b1;
      run_q[$].str_end = eos;
    end
    foreach (run_q[i]) clean_q.insert(clean_q.size(), run_q[i]);
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eos, input int idle,
                            input int stall);
    raw_item_t it;
    it.data      = b;
    it.eos       = eos;
    it.idle_pct  = idle;
    it.stall_pct = stall;
    it.drain     = 1'b0;
    it.hold      = 1'b0;
    raw_q.insert(raw_q.size(), it);
  endtask

  task automatic queue_string(input int idle, input int stall);
    logic [7:0] chars [$];
    logic [7:0] tmp [4];
    int         tlen;
    int         kind;
    int         nchar;
    nchar = $urandom_range(10, 1);
    repeat (nchar) begin
      for (int k = 1; k < 4; k++) tmp[k] = 8'($urandom_range(8'hBF, 8'h80));
      case ($urandom_range(3, 0))
        0: begin
          tmp[0] = 8'($urandom_range(8'h7F, 8'h00));
          tlen = 1;
        end
        1: begin
          tmp[0] = 8'($urandom_range(8'hDF, 8'hC2));
          tlen = 2;
        end
        2: begin
          tmp[0] = 8'($urandom_range(8'hEF, 8'hE0));
          tlen = 3;
        end
        default: begin
          tmp[0] = 8'($urandom_range(8'hF4, 8'hF0));
          tlen = 4;
        end
      endcase
      if (tmp[0] == 8'hE0) tmp[1] = 8'($urandom_range(8'hBF, 8'hA0));
      if (tmp[0] == 8'hED) tmp[1] = 8'($urandom_range(8'h9F, 8'h80));
      if (tmp[0] == 8'hF0) tmp[1] = 8'($urandom_range(8'hBF, 8'h90));
      if (tmp[0] == 8'hF4) tmp[1] = 8'($urandom_range(8'h8F, 8'h80));
      kind = $urandom_range(99, 0);
      if (kind >= 90) begin
        tmp[0] = 8'($urandom);
        tlen = 1;
      end else if (kind >= 80 && tlen > 1) begin
        tmp[$urandom_range(tlen - 1, 1)] = 8'($urandom);
      end else if (kind >= 70 && tlen > 1) begin
        tlen = $urandom_range(tlen - 1, 1);
      end
      for (int k = 0; k < tlen; k++) chars.insert(chars.size(), tmp[k]);
    end
    foreach (chars[i]) queue_byte(chars[i], i == chars.size() - 1, idle, stall);
  endtask

  initial begin : stimulus
    int first;
    rx_if.valid         = 1'b0;
    rx_if.in_byte       = 8'h00;
    rx_if.end_of_string = 1'b0;
    tx_if.ready         = 1'b0;
    held_b              = '{8'h00, 8'h00, 8'h00};
    foreach (warmup[i]) queue_byte(warmup[i][7:0], warmup[i][8], 0, 0);
    for (int p = 0; p < 4; p++) begin
      first = raw_q.size();
      while (raw_q.size() - first < 100) queue_string(phase_idle[p], phase_stall[p]);
      raw_q[first].drain = 1'b1;
      if (p == 0 || p == 3) raw_q[first + 20].hold = 1'b1;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (raw_q.size() != 0 || rx_if.valid || clean_q.size() != 0) @(negedge clk);
    repeat (TailCycles) @(posedge clk);
    if (clean_q.size() != 0) report_mismatch("missing transactions", clean_q.size(), 0);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    logic offer;
    if (rst) begin
      rx_if.valid <= 1'b0;
      hold_kick   <= 1'b0;
    end else begin
      offer = rx_if.valid;
      hold_kick <= rx_if.valid && rx_if.ready && cur_item.hold;
      if (rx_if.valid && rx_if.ready) begin
        sanitize_step(cur_item.data, cur_item.eos);
        offer = 1'b0;
      end
      if (!offer && raw_q.size() != 0 && !(raw_q[0].drain && clean_q.size() != 0)
          && $urandom_range(99, 0) >= raw_q[0].idle_pct) begin
        cur_item = raw_q.pop_front();
        offer = 1'b1;
        rx_if.in_byte       <= cur_item.data;
        rx_if.end_of_string <= cur_item.eos;
        stall_pct_now       <= cur_item.stall_pct;
      end
      rx_if.valid <= offer;
    end
  end

  // hold the output side off for a long stretch so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    clean_byte_t want;
    if (rst) begin
      tx_if.ready <= 1'b0;
    end else begin
      if (tx_if.valid && tx_if.ready) begin
        if (clean_q.size() == 0) begin
          report_mismatch("unexpected transaction", tx_if.out_byte, 0);
        end else begin
          want = clean_q.pop_front();
          if (tx_if.out_byte !== want.data)
            report_mismatch("out_byte", tx_if.out_byte, want.data);
          if (tx_if.run_last !== want.run_end)
            report_mismatch("run_last", tx_if.run_last, want.run_end);
          if (tx_if.string_done !== want.str_end)
            report_mismatch("string_done", tx_if.string_done, want.str_end);
        end
      end
      tx_if.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= stall_pct_now);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
